@@ rtl/core/htip_pkg.sv @@
// ----------------------------------------------------------------------------
// htip_pkg: shared definitions for the hex text parser
// Character codes, phase and status codes, register indexes and the
// hex digit decoder used by the parser; the checker uses the status codes.
// ----------------------------------------------------------------------------
package htip_pkg;

  // Characters that steer the parse.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;

  // Value of the letter digits relative to their base character.
  localparam logic [3:0] LETTER_BASE = 4'd10;

  // Parse phases.
  localparam logic [1:0] PH_SPACES = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_DIGIT = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // Width select codes; the reserved code also means 32 bits.
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SIGNED = 2'd1;
  localparam logic [1:0] CFG_ENDIAN = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nibble_t;

  // Decode one character as a hex digit of either case.
  function automatic nibble_t hex_nibble(input logic [7:0] c);
    nibble_t n;
    n.valid = 1'b0;
    n.value = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      n.valid = 1'b1;
      n.value = c[3:0];
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      n.valid = 1'b1;
      n.value = 4'(c - CHAR_LC_A) + LETTER_BASE;
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      n.valid = 1'b1;
      n.value = 4'(c - CHAR_UC_A) + LETTER_BASE;
    end
    return n;
  endfunction

endpackage

@@ rtl/core/hex_text_to_integer_parser_unit.sv @@
// ----------------------------------------------------------------------------
// hex_text_to_integer_parser_unit: streaming hex number parser
// Takes one character per transaction, skips spaces and a 0x prefix,
// gathers hex digits and returns the range-checked, optionally byte-swapped
// value with a status and the count of characters consumed.
// ----------------------------------------------------------------------------
// A result is registered: it is in the output register in the cycle after the
// character that ends the parse is accepted.
// Throughput: one character per cycle; the input stalls only while a finished
// result waits for out_ready. The parse state update is a compare and a shift-or.
// Reset (rst_n low, synchronous): parse state cleared, registers back to
// 32-bit unsigned big-endian, output register empty.
module hex_text_to_integer_parser_unit #(
  parameter int MAX_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_wdata,
  // Character input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_char,
  input  logic        in_buffer_end,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_parsed_value,
  output logic [1:0]  out_parse_status,
  output logic [15:0] out_chars_consumed
);
  import htip_pkg::*;

  localparam int DCW = $clog2(MAX_DIGITS + 1);
  localparam logic [DCW-1:0] DigitLimit = DCW'(MAX_DIGITS);

  // Configuration registers.
  logic [1:0] width_sel_r;
  logic       signed_mode_r;
  logic       little_endian_r;

  // Parse state.
  logic [1:0]     phase_r, phase_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [15:0]    ccnt_r, ccnt_nxt;
  logic           ovf_r, ovf_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] value_r;
  logic [1:0]  status_r;
  logic [15:0] used_r;

  logic           accept;
  logic           finish;
  logic           do_digit;
  nibble_t        nib;
  logic [31:0]    acc_a;
  logic [DCW-1:0] dcnt_a;
  logic [15:0]    ccnt_a;
  logic           ovf_a;
  logic [1:0]     phase_a;

  logic        fits;
  logic [31:0] masked;
  logic [31:0] value_res;
  logic [1:0]  status_res;
  logic [15:0] used_res;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign nib      = hex_nibble(in_text_char);

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_sel_r     <= WSEL_32;
      signed_mode_r   <= 1'b0;
      little_endian_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_sel_r     <= cfg_wdata;
        CFG_SIGNED: signed_mode_r   <= cfg_wdata[0];
        CFG_ENDIAN: little_endian_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Character step: phase handling, then an optional digit step.
  always_comb begin
    acc_a    = acc_r;
    dcnt_a   = dcnt_r;
    ccnt_a   = ccnt_r;
    ovf_a    = ovf_r;
    phase_a  = phase_r;
    finish   = 1'b0;
    do_digit = 1'b0;
    case (phase_r)
      PH_SPACES: begin
        if (in_text_char == CHAR_SPACE) begin
          if (ccnt_a != COUNT_MAX) ccnt_a = ccnt_a + 16'd1;
          finish = in_buffer_end;
        end else if (in_text_char == CHAR_ZERO && !in_buffer_end) begin
          if (ccnt_a != COUNT_MAX) ccnt_a = ccnt_a + 16'd1;
          phase_a = PH_ZERO;
        end else begin
          phase_a  = PH_DIGITS;
          do_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_a = PH_DIGITS;
        if (in_text_char == CHAR_LC_X) begin
          if (ccnt_a != COUNT_MAX) ccnt_a = ccnt_a + 16'd1;
          finish = in_buffer_end;
        end else begin
          // The held zero becomes a digit.
          if (acc_a[31:28] != 4'd0) ovf_a = 1'b1;
          acc_a  = {acc_a[27:0], 4'd0};
          dcnt_a = dcnt_a + DCW'(1);
          if (dcnt_a >= DigitLimit) finish = 1'b1;
          else do_digit = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      default: ;
    endcase

    if (do_digit) begin
      if (!nib.valid) begin
        finish = 1'b1;
      end else begin
        if (acc_a[31:28] != 4'd0) ovf_a = 1'b1;
        acc_a  = {acc_a[27:0], nib.value};
        dcnt_a = dcnt_a + DCW'(1);
        if (ccnt_a != COUNT_MAX) ccnt_a = ccnt_a + 16'd1;
        if (dcnt_a >= DigitLimit || in_buffer_end) finish = 1'b1;
      end
    end
  end

  // Range check and byte order of the finished value.
  always_comb begin
    case (width_sel_r)
      WSEL_8: begin
        masked = {24'd0, acc_a[7:0]};
        if (signed_mode_r) fits = (acc_a[31:7] == '0) || (acc_a[31:7] == '1);
        else fits = (acc_a[31:8] == '0);
      end
      WSEL_16: begin
        masked = {16'd0, acc_a[15:0]};
        if (signed_mode_r) fits = (acc_a[31:15] == '0) || (acc_a[31:15] == '1);
        else fits = (acc_a[31:16] == '0);
      end
      default: begin
        masked = acc_a;
        fits   = 1'b1;
      end
    endcase
    if (ovf_a) fits = 1'b0;

    value_res = masked;
    if (little_endian_r) begin
      case (width_sel_r)
        WSEL_8:  value_res = masked;
        WSEL_16: value_res = {16'd0, masked[7:0], masked[15:8]};
        default: value_res = {masked[7:0], masked[15:8], masked[23:16], masked[31:24]};
      endcase
    end

    if (dcnt_a == '0) begin
      status_res = ST_NO_DIGIT;
      value_res  = 32'd0;
      used_res   = 16'd0;
    end else if (!fits) begin
      status_res = ST_RANGE;
      value_res  = 32'd0;
      used_res   = 16'd0;
    end else begin
      status_res = ST_OK;
      used_res   = ccnt_a;
    end
  end

  // Next parse state after an accepted character.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    ccnt_nxt  = ccnt_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      acc_nxt  = acc_a;
      dcnt_nxt = dcnt_a;
      ccnt_nxt = ccnt_a;
      ovf_nxt  = ovf_a;
      if (finish) phase_nxt = PH_DONE;
      else phase_nxt = phase_a;
      // The last character of a buffer always starts a fresh parse.
      if (in_buffer_end && (finish || phase_r == PH_DONE)) begin
        phase_nxt = PH_SPACES;
        acc_nxt   = 32'd0;
        dcnt_nxt  = '0;
        ccnt_nxt  = 16'd0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  assign out_valid_nxt = (accept && finish) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACES;
      acc_r       <= 32'd0;
      dcnt_r      <= '0;
      ccnt_r      <= 16'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      dcnt_r      <= dcnt_nxt;
      ccnt_r      <= ccnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded when a parse ends.
  always_ff @(posedge clk) begin
    if (accept && finish) begin
      value_r  <= value_res;
      status_r <= status_res;
      used_r   <= used_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_parsed_value   = value_r;
  assign out_parse_status   = status_r;
  assign out_chars_consumed = used_r;

endmodule

@@ rtl/core/htip_checker.sv @@
// ----------------------------------------------------------------------------
// htip_assertions: port-level checks for the hex text parser
// Watches the result channel for held transactions and consistent
// status, value and count fields, and is bound to the parser unit.
// ----------------------------------------------------------------------------
module htip_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_parsed_value,
  input logic [1:0]  out_parse_status,
  input logic [15:0] out_chars_consumed
);
  import htip_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parsed_value) &&
    $stable(out_parse_status) && $stable(out_chars_consumed))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_parse_status == ST_OK || out_parse_status == ST_NO_DIGIT ||
    out_parse_status == ST_RANGE)
    else $error("undefined status code");

  // A failed parse reports zero value and zero characters.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status != ST_OK |->
    out_parsed_value == 32'd0 && out_chars_consumed == 16'd0)
    else $error("failed parse with nonzero fields");

  // A successful parse reports at least one character consumed.
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parse_status == ST_OK |-> out_chars_consumed != 16'd0)
    else $error("successful parse with no characters consumed");

endmodule

bind hex_text_to_integer_parser_unit htip_assertions u_htip_assertions (.*);
